@@ hdl/kdfc_pkg.sv @@
`timescale 1ns / 1ps

package kdfc_pkg;

  // fixed-point format of angles and speeds
  localparam int FRAC_BITS  = 16;
  localparam int DECAY_BITS = 16;

  // field and register widths
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int STEP_W    = 2;
  localparam int RPP_W     = 19;
  localparam int DECAY_W   = 17;
  localparam int SPEED_W   = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 31;

  // reset values of the registers; all but the decay factor are derived from the fraction width
  localparam longint TWO_PI_Q24 = 64'd105414357;
  localparam longint RESET_PPR  = 64'd24;
  localparam logic [RPP_W-1:0] RPP_RESET =
    RPP_W'((TWO_PI_Q24 >> (24 - FRAC_BITS)) / RESET_PPR);
  localparam logic [DECAY_W-1:0] DECAY_RESET    = DECAY_W'(65503);
  localparam logic [SPEED_W-1:0] STOP_RESET     = SPEED_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [SPEED_W-1:0] DEADBAND_RESET = SPEED_W'(64'd1 << (FRAC_BITS - 2));

  // item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_POLL   = 2'd1,
    FUNC_ENABLE = 2'd2
  } func_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAD_PER_PULSE  = 2'd0,
    REG_DECAY_FACTOR   = 2'd1,
    REG_STOP_SPEED     = 2'd2,
    REG_ADOPT_DEADBAND = 2'd3
  } cfg_reg_t;

  // report step codes
  localparam logic [STEP_W-1:0] STEP_NONE = 2'b00;
  localparam logic [STEP_W-1:0] STEP_UP   = 2'b01;
  localparam logic [STEP_W-1:0] STEP_DOWN = 2'b11;

endpackage

@@ hdl/knob_detent_and_flywheel_coast.sv @@
`timescale 1ns / 1ps

// detent counter and flywheel coast for a motorized knob
//
// input channel (in_valid/in_ready) carries one word per item: a tick,
// a report poll or an enable command, with the knob position and speed.
// result channel (out_valid/out_ready) gives exactly one word per item:
// the velocity target and, for a poll, the report flag and step.
// cfg_we/cfg_index/cfg_data write one of the four settings per cycle;
// write them only while no item is in flight.
//
// an accepted word is held in the input register, and its result is
// loaded into the output register when that register is free or drains;
// the result then stays on the out_ ports until it is taken. throughput
// is one item per cycle while the receiver takes every result; the
// flywheel multiply (32x17) and its compares set the clock.
// when the receiver stalls, the output register holds; the input
// register still takes one more word, then in_ready drops.
// reset clears the state, both valid flags and loads the default settings.

module knob_detent_and_flywheel_coast import kdfc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [FUNC_W-1:0]           in_func,
  input  logic signed [DATA_W-1:0]    in_knob_position,
  input  logic signed [DATA_W-1:0]    in_knob_speed,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DATA_W-1:0]    out_velocity_target,
  output logic                        out_report_ready,
  output logic signed [STEP_W-1:0]    out_report_step
);

  // settings
  logic [RPP_W-1:0]   rad_per_pulse_r;
  logic [DECAY_W-1:0] decay_factor_r;
  logic [SPEED_W-1:0] stop_speed_r;
  logic [SPEED_W-1:0] adopt_deadband_r;

  // knob state
  logic [DATA_W-1:0] reference_angle_r, reference_angle_nxt;
  logic [DATA_W-1:0] pulse_count_r,     pulse_count_nxt;
  logic [DATA_W-1:0] reported_count_r,  reported_count_nxt;
  logic [DATA_W-1:0] flywheel_speed_r,  flywheel_speed_nxt;

  // input register
  logic              s1_valid_r;
  logic [FUNC_W-1:0] s1_func_r;
  logic [DATA_W-1:0] s1_pos_r;
  logic [DATA_W-1:0] s1_spd_r;

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_velocity_r;
  logic              out_ready_flag_r, out_ready_flag_nxt;
  logic [STEP_W-1:0] out_step_r,       out_step_nxt;

  logic advance;

  // tick datapath
  logic [DATA_W:0]   move;
  logic [DATA_W+1:0] move_x2;
  logic [DATA_W+1:0] rpp_ext;
  logic              step_up;
  logic              step_down;
  logic [DATA_W-1:0] fw_tick;

  // the input register moves on when the output register is free or drains
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign out_valid           = out_valid_r;
  assign out_velocity_target = out_velocity_r;
  assign out_report_ready    = out_ready_flag_r;
  assign out_report_step     = out_step_r;

  // exact move from the reference, compared as twice the move
  assign move      = {s1_pos_r[DATA_W-1], s1_pos_r}
                   - {reference_angle_r[DATA_W-1], reference_angle_r};
  assign move_x2   = {move, 1'b0};
  assign rpp_ext   = {{(DATA_W+2-RPP_W){1'b0}}, rad_per_pulse_r};
  assign step_up   = $signed(move_x2) >= $signed(rpp_ext);
  assign step_down = $signed(move_x2) <= -$signed(rpp_ext);

  kdfc_flywheel u_flywheel (
    .fw             (flywheel_speed_r),
    .spd            (s1_spd_r),
    .decay_factor   (decay_factor_r),
    .stop_speed     (stop_speed_r),
    .adopt_deadband (adopt_deadband_r),
    .fw_nxt         (fw_tick)
  );

  // next state and result of the word in the input register
  always_comb begin
    reference_angle_nxt = reference_angle_r;
    pulse_count_nxt     = pulse_count_r;
    reported_count_nxt  = reported_count_r;
    flywheel_speed_nxt  = flywheel_speed_r;
    out_ready_flag_nxt  = 1'b0;
    out_step_nxt        = STEP_NONE;
    case (s1_func_r)
      FUNC_TICK: begin
        if (step_up) begin
          reference_angle_nxt = reference_angle_r + {{(DATA_W-RPP_W){1'b0}}, rad_per_pulse_r};
          pulse_count_nxt     = pulse_count_r + DATA_W'(1);
        end else if (step_down) begin
          reference_angle_nxt = reference_angle_r - {{(DATA_W-RPP_W){1'b0}}, rad_per_pulse_r};
          pulse_count_nxt     = pulse_count_r - DATA_W'(1);
        end
        flywheel_speed_nxt = fw_tick;
      end
      FUNC_POLL: begin
        if (pulse_count_r != reported_count_r) begin
          out_ready_flag_nxt = 1'b1;
          out_step_nxt       = ($signed(pulse_count_r) > $signed(reported_count_r)) ?
                               STEP_UP : STEP_DOWN;
          reported_count_nxt = pulse_count_r;
        end
      end
      FUNC_ENABLE: begin
        // rezero on the current position
        reference_angle_nxt = s1_pos_r;
        pulse_count_nxt     = '0;
        reported_count_nxt  = '0;
        flywheel_speed_nxt  = '0;
      end
      default: begin
        // unused code leaves the state alone
      end
    endcase
  end

  // settings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_per_pulse_r  <= RPP_RESET;
      decay_factor_r   <= DECAY_RESET;
      stop_speed_r     <= STOP_RESET;
      adopt_deadband_r <= DEADBAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAD_PER_PULSE:  rad_per_pulse_r  <= cfg_data[RPP_W-1:0];
        REG_DECAY_FACTOR:   decay_factor_r   <= cfg_data[DECAY_W-1:0];
        REG_STOP_SPEED:     stop_speed_r     <= cfg_data[SPEED_W-1:0];
        REG_ADOPT_DEADBAND: adopt_deadband_r <= cfg_data[SPEED_W-1:0];
      endcase
    end
  end

  // state and valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reference_angle_r <= '0;
      pulse_count_r     <= '0;
      reported_count_r  <= '0;
      flywheel_speed_r  <= '0;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        reference_angle_r <= reference_angle_nxt;
        pulse_count_r     <= pulse_count_nxt;
        reported_count_r  <= reported_count_nxt;
        flywheel_speed_r  <= flywheel_speed_nxt;
        out_valid_r       <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r <= in_func;
      s1_pos_r  <= in_knob_position;
      s1_spd_r  <= in_knob_speed;
    end
    if (advance) begin
      out_velocity_r   <= flywheel_speed_nxt;
      out_ready_flag_r <= out_ready_flag_nxt;
      out_step_r       <= out_step_nxt;
    end
  end

endmodule

@@ hdl/kdfc_flywheel.sv @@
`timescale 1ns / 1ps

module kdfc_flywheel import kdfc_pkg::*; (
  input  logic [DATA_W-1:0]  fw,
  input  logic [DATA_W-1:0]  spd,
  input  logic [DECAY_W-1:0] decay_factor,
  input  logic [SPEED_W-1:0] stop_speed,
  input  logic [SPEED_W-1:0] adopt_deadband,
  output logic [DATA_W-1:0]  fw_nxt
);

  logic [DATA_W-1:0]         fw_mag;
  logic [DATA_W-1:0]         spd_mag;
  logic [DATA_W:0]           adopt_lim;
  logic [DATA_W+DECAY_W-1:0] prod;
  logic [DATA_W:0]           dec_mag;

  // magnitudes are exact as unsigned 32-bit values
  assign fw_mag    = fw[DATA_W-1]  ? (~fw + DATA_W'(1))  : fw;
  assign spd_mag   = spd[DATA_W-1] ? (~spd + DATA_W'(1)) : spd;
  assign adopt_lim = {1'b0, fw_mag} + {2'b00, adopt_deadband};
  assign prod      = {{DECAY_W{1'b0}}, fw_mag} * {{DATA_W{1'b0}}, decay_factor};
  assign dec_mag   = prod[DATA_W+DECAY_W-1:DECAY_BITS];

  always_comb begin
    priority if (spd_mag < {1'b0, stop_speed}) begin
      fw_nxt = '0;
    end else if ({1'b0, spd_mag} > adopt_lim) begin
      fw_nxt = spd;
    end else if (dec_mag < {2'b00, stop_speed}) begin
      fw_nxt = '0;
    end else if (!fw[DATA_W-1]) begin
      // positive decay result, clamp at the top of the range
      if (dec_mag > {2'b00, {(DATA_W-1){1'b1}}}) begin
        fw_nxt = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        fw_nxt = dec_mag[DATA_W-1:0];
      end
    end else begin
      // negative decay result, clamp at the bottom of the range
      if (dec_mag > {2'b01, {(DATA_W-1){1'b0}}}) begin
        fw_nxt = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        fw_nxt = ~dec_mag[DATA_W-1:0] + DATA_W'(1);
      end
    end
  end

endmodule
